### src/hvt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvt_pkg
// Shared widths, types and codes of the homogeneous vertex transform.
// ----------------------------------------------------------------------------
package hvt_pkg;

	localparam int FracBitsDef = 16;
	localparam int CoefW       = 32;
	localparam int PosW        = 32;
	localparam int ProdW       = 2 * CoefW;
	localparam int AccW        = ProdW + 2;
	localparam int QuotW       = 32;
	localparam int RemW        = AccW + QuotW;
	localparam int NumRegs     = 8;
	localparam int CfgIdxW     = 3;
	localparam int CfgW        = 64;
	localparam int MatLat      = 3;
	localparam int LaneLat     = 2 + QuotW;

	typedef logic signed [CoefW-1:0] coef_t;
	typedef logic signed [AccW-1:0]  acc_t;
	typedef logic [CfgW-1:0]         cfg_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_W_SMALL  = 2'd1,
		STATUS_OVERFLOW = 2'd2
	} status_t;

	// result of one divider lane
	typedef struct packed {
		logic [QuotW-1:0] quot;
		logic             neg;
		logic             big;
	} lane_res_t;

	// identity matrix after reset
	localparam cfg_t CfgReset [NumRegs] = '{
		64'd65536, 64'd0,
		64'd281474976710656, 64'd0,
		64'd0, 64'd65536,
		64'd0, 64'd281474976710656
	};

endpackage

### src/homogeneous_vertex_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform
// Vertex times configured 4x4 matrix with w = 1, then perspective divide of
// x, y and z by w, with near-zero w and quotient overflow status.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-----------------------------------
//   vertex   | vtx_valid / vtx_ready | pos_x, pos_y, pos_z, last_in
//   texture  | tex_valid / tex_ready | tex_x, tex_y, tex_z, status, last_out
//   config   | cfg_we                | cfg_index, cfg_data
//
// One vertex per cycle while vtx_ready is high, through 3 matrix stages, 2 divider
// setup stages, 32 divider stages of one quotient bit each and 1 result stage.
// All stages advance together; a skid register behind the result stage takes
// one result when the consumer stalls, after which vtx_ready drops.
// Reset loads the identity matrix and empties the pipeline.
// ----------------------------------------------------------------------------
module homogeneous_vertex_transform #(
	parameter int FRAC_BITS = hvt_pkg::FracBitsDef
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               vtx_valid,
	output logic                               vtx_ready,
	input  logic signed [hvt_pkg::PosW-1:0]    pos_x,
	input  logic signed [hvt_pkg::PosW-1:0]    pos_y,
	input  logic signed [hvt_pkg::PosW-1:0]    pos_z,
	input  logic                               last_in,
	output logic                               tex_valid,
	input  logic                               tex_ready,
	output logic signed [hvt_pkg::QuotW-1:0]   tex_x,
	output logic signed [hvt_pkg::QuotW-1:0]   tex_y,
	output logic signed [hvt_pkg::QuotW-1:0]   tex_z,
	output logic [1:0]                         status,
	output logic                               last_out,
	input  logic                               cfg_we,
	input  logic [hvt_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [hvt_pkg::CfgW-1:0]           cfg_data
);

	localparam int AW    = hvt_pkg::AccW;
	localparam int QW    = hvt_pkg::QuotW;
	localparam int Depth = hvt_pkg::MatLat + hvt_pkg::LaneLat;
	localparam int LL    = hvt_pkg::LaneLat;
	localparam logic [AW-1:0] WEps = AW'((64'd1 << (2 * FRAC_BITS)) / 64'd1000000);

	hvt_pkg::cfg_t      cfg_q [hvt_pkg::NumRegs];
	hvt_pkg::coef_t     coef  [4][4];
	hvt_pkg::acc_t      acc   [4];
	hvt_pkg::lane_res_t lane  [3];

	logic              en;
	logic              line_vld_s  [Depth];
	logic              line_last_s [Depth];
	logic              eps_s       [LL];
	logic [AW-1:0]     hw_abs;
	logic              eps_now;

	logic [QW-1:0]     tex_d [3];
	logic              ovf_d;
	hvt_pkg::status_t  status_d;

	logic              res_valid_s;
	logic              res_last_s;
	logic [QW-1:0]     res_tex_s [3];
	hvt_pkg::status_t  res_status_s;

	logic              skid_valid_q;
	logic              skid_last_q;
	logic [QW-1:0]     skid_tex_q [3];
	hvt_pkg::status_t  skid_status_q;

	assign en        = !skid_valid_q;
	assign vtx_ready = en;

	// matrix registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < hvt_pkg::NumRegs; i++) cfg_q[i] <= hvt_pkg::CfgReset[i];
		end else if (cfg_we) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// coefficient unpacking, column 0 and 2 in the low half
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				coef[r][c] = cfg_q[2 * r + c / 2][32 * (c % 2) +: hvt_pkg::CoefW];
			end
		end
	end

	hvt_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
		.clk   (clk),
		.en    (en),
		.pos_x (pos_x),
		.pos_y (pos_y),
		.pos_z (pos_z),
		.coef  (coef),
		.acc   (acc)
	);

	for (genvar l = 0; l < 3; l++) begin : g_lane
		hvt_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk (clk),
			.en  (en),
			.num (acc[l]),
			.den (acc[3]),
			.res (lane[l])
		);
	end

	// near-zero w test on the accumulator
	assign hw_abs  = acc[3][AW-1] ? AW'(-acc[3]) : AW'(acc[3]);
	assign eps_now = hw_abs <= WEps;

	// valid and last travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < Depth; i++) line_vld_s[i] <= 1'b0;
		end else if (en) begin
			line_vld_s[0] <= vtx_valid;
			for (int i = 1; i < Depth; i++) line_vld_s[i] <= line_vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			line_last_s[0] <= last_in;
			for (int i = 1; i < Depth; i++) line_last_s[i] <= line_last_s[i-1];
			eps_s[0] <= eps_now;
			for (int i = 1; i < LL; i++) eps_s[i] <= eps_s[i-1];
		end
	end

	// sign, range limit and status
	always_comb begin
		ovf_d = 1'b0;
		for (int l = 0; l < 3; l++) begin
			if (lane[l].big || lane[l].quot > (lane[l].neg ? {1'b1, {(QW-1){1'b0}}}
					: {1'b0, {(QW-1){1'b1}}})) begin
				ovf_d = 1'b1;
			end
			tex_d[l] = lane[l].neg ? QW'(-lane[l].quot) : lane[l].quot;
		end
		priority if (eps_s[LL-1]) begin
			status_d = hvt_pkg::STATUS_W_SMALL;
		end else if (ovf_d) begin
			status_d = hvt_pkg::STATUS_OVERFLOW;
		end else begin
			status_d = hvt_pkg::STATUS_OK;
		end
		if (status_d != hvt_pkg::STATUS_OK) begin
			for (int l = 0; l < 3; l++) tex_d[l] = '0;
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s <= 1'b0;
		end else if (en) begin
			res_valid_s <= line_vld_s[Depth-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_last_s   <= line_last_s[Depth-1];
			res_tex_s    <= tex_d;
			res_status_s <= status_d;
		end
	end

	// skid register for a stalled transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (tex_ready) skid_valid_q <= 1'b0;
		end else if (res_valid_s && !tex_ready) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_valid_q) begin
			skid_last_q   <= res_last_s;
			skid_tex_q    <= res_tex_s;
			skid_status_q <= res_status_s;
		end
	end

	// output select
	assign tex_valid = skid_valid_q || res_valid_s;
	assign tex_x     = skid_valid_q ? skid_tex_q[0] : res_tex_s[0];
	assign tex_y     = skid_valid_q ? skid_tex_q[1] : res_tex_s[1];
	assign tex_z     = skid_valid_q ? skid_tex_q[2] : res_tex_s[2];
	assign status    = skid_valid_q ? skid_status_q : res_status_s;
	assign last_out  = skid_valid_q ? skid_last_q : res_last_s;

	// a failed vertex carries zero coordinates
	a_bad_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		tex_valid && status != hvt_pkg::STATUS_OK |-> tex_x == 0 && tex_y == 0 && tex_z == 0)
		else $error("nonzero coordinate with failing status");

	// the skid only fills on a stalled transfer
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(tex_valid && !tex_ready))
		else $error("skid filled without a stall");

	// pipeline holds while the skid is full
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && $past(skid_valid_q) |-> $stable(res_valid_s) && $stable(res_tex_s[0]))
		else $error("result stage moved during stall");

endmodule

### src/hvt_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvt_matrix
// Three stage 4x4 matrix times (x, y, z, 1): products, pair sums, row sums.
// ----------------------------------------------------------------------------
module hvt_matrix #(
	parameter int FRAC_BITS = hvt_pkg::FracBitsDef
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [hvt_pkg::PosW-1:0] pos_x,
	input  logic signed [hvt_pkg::PosW-1:0] pos_y,
	input  logic signed [hvt_pkg::PosW-1:0] pos_z,
	input  hvt_pkg::coef_t      coef [4][4],
	output hvt_pkg::acc_t       acc [4]
);

	logic signed [hvt_pkg::ProdW-1:0]   prod_d  [4][4];
	logic signed [hvt_pkg::ProdW-1:0]   prod_s1 [4][4];
	logic signed [hvt_pkg::ProdW:0]     pair_s2 [4][2];
	hvt_pkg::acc_t                      acc_s3  [4];
	logic signed [hvt_pkg::PosW-1:0]    pos     [3];

	assign pos[0] = pos_x;
	assign pos[1] = pos_y;
	assign pos[2] = pos_z;

	// products; the w column is a shift since w is one
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 3; c++) begin
				prod_d[r][c] = hvt_pkg::ProdW'(coef[r][c]) * hvt_pkg::ProdW'(pos[c]);
			end
			prod_d[r][3] = {{(hvt_pkg::CoefW-FRAC_BITS){coef[r][3][hvt_pkg::CoefW-1]}},
				coef[r][3], {FRAC_BITS{1'b0}}};
		end
	end

	// stage registers
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 4; c++) begin
					prod_s1[r][c] <= prod_d[r][c];
				end
				pair_s2[r][0] <= (hvt_pkg::ProdW+1)'(prod_s1[r][0])
					+ (hvt_pkg::ProdW+1)'(prod_s1[r][1]);
				pair_s2[r][1] <= (hvt_pkg::ProdW+1)'(prod_s1[r][2])
					+ (hvt_pkg::ProdW+1)'(prod_s1[r][3]);
				acc_s3[r] <= hvt_pkg::AccW'(pair_s2[r][0]) + hvt_pkg::AccW'(pair_s2[r][1]);
			end
		end
	end

	assign acc = acc_s3;

endmodule

### src/hvt_div_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvt_div_lane
// Pipelined restoring divider: |num| << FRAC_BITS over |den|, one quotient
// bit per stage, with a flag for quotients of 2^32 and above.
// ----------------------------------------------------------------------------
module hvt_div_lane #(
	parameter int FRAC_BITS = hvt_pkg::FracBitsDef
) (
	input  logic               clk,
	input  logic               en,
	input  hvt_pkg::acc_t      num,
	input  hvt_pkg::acc_t      den,
	output hvt_pkg::lane_res_t res
);

	localparam int QW = hvt_pkg::QuotW;
	localparam int RW = hvt_pkg::RemW;
	localparam int AW = hvt_pkg::AccW;

	logic [AW-1:0] num_abs_s1;
	logic [AW-1:0] den_abs_s1;
	logic          neg_s1;

	logic [RW-1:0] step_rem_s  [QW+1];
	logic [AW-1:0] step_den_s  [QW+1];
	logic [QW-1:0] step_quot_s [QW+1];
	logic          step_neg_s  [QW+1];
	logic          step_big_s  [QW+1];

	logic [RW-1:0] num_ext;
	logic [RW-1:0] den_top;

	assign num_ext = RW'(num_abs_s1) << FRAC_BITS;
	assign den_top = RW'(den_abs_s1) << QW;

	// magnitudes and result sign
	always_ff @(posedge clk) begin
		if (en) begin
			num_abs_s1 <= num[AW-1] ? AW'(-num) : AW'(num);
			den_abs_s1 <= den[AW-1] ? AW'(-den) : AW'(den);
			neg_s1     <= num[AW-1] ^ den[AW-1];
		end
	end

	// scaled numerator and range check
	always_ff @(posedge clk) begin
		if (en) begin
			step_rem_s[0]  <= num_ext;
			step_den_s[0]  <= den_abs_s1;
			step_quot_s[0] <= '0;
			step_neg_s[0]  <= neg_s1;
			step_big_s[0]  <= num_ext >= den_top;
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar k = 0; k < QW; k++) begin : g_step
		localparam int Sh = QW - 1 - k;
		logic [RW:0] trial;
		assign trial = {1'b0, step_rem_s[k]} - {1'b0, RW'(step_den_s[k]) << Sh};

		always_ff @(posedge clk) begin
			if (en) begin
				step_rem_s[k+1]  <= trial[RW] ? step_rem_s[k] : trial[RW-1:0];
				step_quot_s[k+1] <= {step_quot_s[k][QW-2:0], ~trial[RW]};
				step_den_s[k+1]  <= step_den_s[k];
				step_neg_s[k+1]  <= step_neg_s[k];
				step_big_s[k+1]  <= step_big_s[k];
			end
		end
	end

	assign res = '{quot: step_quot_s[QW], neg: step_neg_s[QW], big: step_big_s[QW]};

endmodule

### verif/hvt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvt_checker
// Watches the vertex, texture and config ports of the vertex transform,
// predicts each texture result from the accepted vertex and the matrix
// written so far, and compares results in order, field by field.
// ----------------------------------------------------------------------------
module hvt_checker
	import hvt_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   vtx_valid,
	input  logic                   vtx_ready,
	input  logic signed [PosW-1:0] pos_x,
	input  logic signed [PosW-1:0] pos_y,
	input  logic signed [PosW-1:0] pos_z,
	input  logic                   last_in,
	input  logic                   tex_valid,
	input  logic                   tex_ready,
	input  logic signed [QuotW-1:0] tex_x,
	input  logic signed [QuotW-1:0] tex_y,
	input  logic signed [QuotW-1:0] tex_z,
	input  logic [1:0]             status,
	input  logic                   last_out,
	input  logic                   cfg_we,
	input  logic [CfgIdxW-1:0]     cfg_index,
	input  logic [CfgW-1:0]        cfg_data,
	output int                     fail_count,
	output int                     tex_pending
);

	localparam int FracBits = FracBitsDef;
	localparam logic [127:0] WEps = (128'd1 << (2 * FracBits)) / 128'd1000000;

	typedef struct {
		logic [QuotW-1:0] x;
		logic [QuotW-1:0] y;
		logic [QuotW-1:0] z;
		status_t          st;
		logic             last;
	} texel_t;

	cfg_t   matrix_regs [NumRegs];
	texel_t texel_queue [$];

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	// one lane of the perspective divide, truncated toward zero
	function automatic logic divide_lane(input logic signed [127:0] num,
			input logic signed [127:0] den, output logic [QuotW-1:0] quot);
		logic         neg;
		logic [127:0] q;
		logic [127:0] lim;
		neg  = num[127] != den[127];
		q    = ((num[127] ? -num : num) << FracBits) / (den[127] ? -den : den);
		lim  = neg ? 128'h8000_0000 : 128'h7fff_ffff;
		quot = neg ? -q[QuotW-1:0] : q[QuotW-1:0];
		return q > lim;
	endfunction

	function automatic texel_t transform_vertex(input logic signed [PosW-1:0] px,
			input logic signed [PosW-1:0] py, input logic signed [PosW-1:0] pz,
			input logic lst);
		logic signed [127:0] p   [4];
		logic signed [127:0] acc [4];
		logic signed [127:0] c;
		logic [QuotW-1:0]    q   [3];
		logic                ovf;
		texel_t              t;
		p[0] = px;
		p[1] = py;
		p[2] = pz;
		p[3] = 128'sd1 <<< FracBits;
		for (int r = 0; r < 4; r++) begin
			acc[r] = 0;
			for (int k = 0; k < 4; k++) begin
				c = coef_t'(matrix_regs[r * 2 + k / 2][32 * (k % 2) +: 32]);
				acc[r] += c * p[k];
			end
		end
		t.x = '0; t.y = '0; t.z = '0;
		t.last = lst;
		if ((acc[3][127] ? -acc[3] : acc[3]) <= WEps) begin
			t.st = STATUS_W_SMALL;
		end else begin
			ovf = 1'b0;
			for (int r = 0; r < 3; r++) ovf |= divide_lane(acc[r], acc[3], q[r]);
			if (ovf) begin
				t.st = STATUS_OVERFLOW;
			end else begin
				t.st = STATUS_OK;
				t.x = q[0]; t.y = q[1]; t.z = q[2];
			end
		end
		return t;
	endfunction

	// register writes, accepted vertices and results, sampled at the edge
	always @(posedge clk) begin
		texel_t w;
		if (!arst_n) begin
			for (int i = 0; i < NumRegs; i++) matrix_regs[i] = CfgReset[i];
		end else begin
			// a vertex sees the matrix as it was before a write in the same edge
			if (vtx_valid && vtx_ready)
				texel_queue = {texel_queue,
					transform_vertex(pos_x, pos_y, pos_z, last_in)};
			if (cfg_we) matrix_regs[cfg_index] = cfg_data;
			if (tex_valid && tex_ready) begin
				if (texel_queue.size() == 0) begin
					report("unexpected texture transfer", tex_x, 32'h0);
				end else begin
					w = texel_queue.pop_front();
					if (tex_x !== w.x) report("tex_x", tex_x, w.x);
					if (tex_y !== w.y) report("tex_y", tex_y, w.y);
					if (tex_z !== w.z) report("tex_z", tex_z, w.z);
					if (status !== w.st) report("status", status, w.st);
					if (last_out !== w.last) report("last_out", last_out, w.last);
				end
			end
			tex_pending = texel_queue.size();
		end
	end

endmodule

### verif/homogeneous_vertex_transform_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform_test
// Drives vertices through a series of matrix settings (identity, degenerate
// w row, huge scale, random affine and projective, extreme coefficients)
// under random idling on both sides and a long consumer stall; results are
// checked by hvt_checker.
// ----------------------------------------------------------------------------
module homogeneous_vertex_transform_test;
	import hvt_pkg::*;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    vtx_valid = 1'b0;
	logic                    vtx_ready;
	logic signed [PosW-1:0]  pos_x = '0;
	logic signed [PosW-1:0]  pos_y = '0;
	logic signed [PosW-1:0]  pos_z = '0;
	logic                    last_in = 1'b0;
	logic                    tex_valid;
	logic                    tex_ready = 1'b0;
	logic signed [QuotW-1:0] tex_x;
	logic signed [QuotW-1:0] tex_y;
	logic signed [QuotW-1:0] tex_z;
	logic [1:0]              status;
	logic                    last_out;
	logic                    cfg_we = 1'b0;
	logic [CfgIdxW-1:0]      cfg_index = '0;
	logic [CfgW-1:0]         cfg_data = '0;
	int                      fail_count;
	int                      tex_pending;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_seq    = 0;
	int hold_seen   = 0;
	int stall_left  = 0;

	localparam logic [31:0] One = 32'h0001_0000;

	homogeneous_vertex_transform u_dut (.*);
	hvt_checker u_checker (.*);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// consumer: random ready, plus a long counted hold-off on request
	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen  <= hold_seq;
			stall_left <= 300;
			tex_ready  <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			tex_ready  <= 1'b0;
		end else begin
			tex_ready <= $urandom_range(99) >= rx_idle_pct;
		end
	end

	// run limit
	initial begin
		#5ms;
		$display("homogeneous_vertex_transform regression: fail");
		$finish;
	end

	task automatic send_vertex(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input logic lst);
		while ($urandom_range(99) < tx_idle_pct) begin
			vtx_valid <= 1'b0;
			@(posedge clk);
		end
		vtx_valid <= 1'b1;
		pos_x     <= x;
		pos_y     <= y;
		pos_z     <= z;
		last_in   <= lst;
		@(posedge clk);
		while (!vtx_ready) @(posedge clk);
	endtask

	// wait for the pipeline to drain before touching the matrix
	task automatic drain();
		vtx_valid <= 1'b0;
		@(posedge clk);
		while (tex_pending != 0) @(posedge clk);
		repeat (45) @(posedge clk);
	endtask

	// write enable stays high across a run of writes
	task automatic write_reg(input int idx, input logic [63:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx[CfgIdxW-1:0];
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic write_matrix(input logic [31:0] m [16]);
		for (int i = 0; i < NumRegs; i++) write_reg(i, {m[2 * i + 1], m[2 * i]});
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_word(input int kind);
		case (kind)
			0: return $urandom;
			1: return $urandom_range(0, 32'h3_ffff) - 32'h2_0000;
			2: case ($urandom_range(3))
				0: return 32'h8000_0000;
				1: return 32'h7fff_ffff;
				2: return 32'hffff_ffff;
				default: return 32'h0;
			endcase
			default: return $urandom_range(0, 32'h7ff_ffff) - 32'h400_0000;
		endcase
	endfunction

	function automatic logic [31:0] rand_pos();
		return rand_word($urandom_range(3));
	endfunction

	task automatic random_matrix(input int kind);
		logic [31:0] m [16];
		for (int i = 0; i < 16; i++) begin
			case (kind)
				0: m[i] = rand_word(1);
				1: m[i] = rand_word($urandom_range(1) ? 1 : 3);
				2: m[i] = rand_word(0);
				default: m[i] = rand_word(2);
			endcase
		end
		// keep w away from zero for the well-conditioned kinds
		if (kind < 2) begin
			m[12] = $urandom_range(0, 32'h3ff) - 32'h200;
			m[13] = $urandom_range(0, 32'h3ff) - 32'h200;
			m[14] = $urandom_range(0, 32'h3ff) - 32'h200;
			m[15] = $urandom_range(1) ? One * $urandom_range(1, 4) : -One;
		end
		write_matrix(m);
	endtask

	task automatic random_burst(input int count);
		for (int i = 0; i < count; i++)
			send_vertex(rand_pos(), rand_pos(), rand_pos(), $urandom_range(15) == 0);
	endtask

	initial begin
		logic [31:0] m [16];
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity after reset: extremes pass straight through
		send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0, 1'b0);
		send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1'b1);
		send_vertex(32'h0, 32'h0, 32'h0, 1'b0);
		send_vertex(32'hffff_ffff, 32'h0000_0001, 32'h5555_aaaa, 1'b1);
		drain();

		// w row zero: near-zero w, then w just above threshold with big x
		for (int i = 0; i < 16; i++) m[i] = 32'h0;
		m[0] = One; m[5] = One; m[10] = One;
		write_matrix(m);
		send_vertex(32'h1234, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
		drain();
		m[15] = 32'd1;
		write_matrix(m);
		send_vertex(32'h1, 32'h2, 32'h3, 1'b0);
		send_vertex(32'h7fff_ffff, 32'h0, 32'h0, 1'b1);
		drain();

		// negative w with unit x row: signs flip, and a minimum coordinate overflows
		m[15] = -One;
		write_matrix(m);
		send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 1'b0);
		send_vertex(32'h8000_0000, 32'h0, 32'h0, 1'b0);
		send_vertex(32'h0, 32'h0, 32'hffff_ffff, 1'b1);
		drain();

		// huge scale: the first vertex overflows the quotient on every lane
		for (int i = 0; i < 16; i++) m[i] = 32'h0;
		m[0] = 32'h7fff_ffff; m[5] = 32'h8000_0000; m[10] = 32'h7fff_ffff;
		m[15] = One;
		write_matrix(m);
		send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
		send_vertex(32'h0, 32'h0, 32'h0, 1'b1);
		send_vertex(32'h0000_0001, 32'h0, 32'h0, 1'b0);
		drain();

		// random phases: receiver idles most, then sender, then neither
		for (int ph = 0; ph < 8; ph++) begin
			tx_idle_pct = (ph < 3) ? 20 : (ph < 6) ? 76 : 0;
			rx_idle_pct = (ph < 3) ? 76 : (ph < 6) ? 20 : 0;
			random_matrix(ph % 4);
			random_burst(60);
			if (ph == 4) begin
				hold_seq++;
				random_burst(40);
			end
			// pause until everything is out, then resume
			drain();
			random_burst(80);
			drain();
		end

		// back to the extremes of the matrix
		for (int i = 0; i < 16; i++) m[i] = 32'h8000_0000;
		write_matrix(m);
		random_burst(20);
		drain();
		for (int i = 0; i < 16; i++) m[i] = 32'h7fff_ffff;
		write_matrix(m);
		random_burst(20);
		drain();

		if (fail_count == 0)
			$display("homogeneous_vertex_transform regression: pass");
		else
			$display("homogeneous_vertex_transform regression: fail");
		$finish;
	end

endmodule
